// ===== hdl/rpn_pkg.sv =====
`default_nettype none
package rpn_pkg;
  localparam int STACK_DEPTH = 16;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0, CMD_ADD = 3'd1, CMD_SUB = 3'd2, CMD_MUL = 3'd3,
    CMD_DIV = 3'd4, CMD_DUP = 3'd5, CMD_SWAP = 3'd6, CMD_NOP = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_FULL = 3'd2, ST_OVER = 3'd3,
    ST_UNDER = 3'd4, ST_ZDIV = 3'd5
  } status_t;

  // shift operation applied to every cell at once
  typedef enum logic [1:0] {
    SH_HOLD = 2'd0, SH_PUSH = 2'd1, SH_POP = 2'd2, SH_SWAP = 2'd3
  } shift_t;

  typedef struct packed {
    shift_t      op;
    logic [31:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               top_valid;
    logic signed [31:0] top_value;
    logic [4:0]         fill_level;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_POP, S_ARITH, S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== hdl/rpn_cell.sv =====
`default_nettype none
// One stack entry; pushes shift down, pops shift up.
module rpn_cell (
  input  wire logic                 clk,
  input  wire rpn_pkg::cell_ctl_t   ctl,
  input  wire logic [31:0]          above,
  input  wire logic [31:0]          below,
  input  wire logic                 is_top,
  input  wire logic                 is_second,
  output logic [31:0]               value
);
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      rpn_pkg::SH_PUSH: value <= is_top ? ctl.value : above;
      rpn_pkg::SH_POP:  value <= below;
      rpn_pkg::SH_SWAP: begin
        if (is_top) value <= below;
        else if (is_second) value <= above;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/rpn_alu.sv =====
`default_nettype none
// Add and subtract, plus iterative 32x32 multiply (shift-add) and restoring divide, one bit a cycle.
module rpn_alu (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [2:0]         cmd,
  input  wire logic signed [31:0] y,
  input  wire logic signed [31:0] x,
  output logic                    done,
  output logic [2:0]              status,
  output logic [31:0]             result
);
  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] acc;
  logic [31:0] mc;
  logic [32:0] rem;
  logic        neg;
  logic        is_div;
  logic signed [32:0] sum;
  logic [33:0] trial;
  logic signed [64:0] prod;

  assign sum = (cmd == rpn_pkg::CMD_SUB) ? ($signed({y[31], y}) - $signed({x[31], x}))
                                          : ($signed({y[31], y}) + $signed({x[31], x}));
  assign trial = {rem, acc[31]} - {2'b0, mc};
  assign prod = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      is_div <= (cmd == rpn_pkg::CMD_DIV);
      neg    <= x[31] ^ y[31];
      mc     <= x[31] ? 32'(-x) : x;
      acc    <= {32'b0, (y[31] ? 32'(-y) : y)};
      rem    <= '0;
      cnt    <= '0;
      if (cmd == rpn_pkg::CMD_ADD || cmd == rpn_pkg::CMD_SUB) begin
        done   <= 1'b1;
        result <= sum[31:0];
        status <= (sum > 33'sd2147483647) ? rpn_pkg::ST_OVER :
                  (sum < -33'sd2147483648) ? rpn_pkg::ST_UNDER : rpn_pkg::ST_OK;
      end else if (cmd == rpn_pkg::CMD_DIV && x == 0) begin
        done   <= 1'b1;
        status <= rpn_pkg::ST_ZDIV;
        result <= '0;
      end else begin
        done <= 1'b0;
        busy <= 1'b1;
      end
    end else if (busy) begin
      done <= (cnt == 6'd32);
      if (cnt == 6'd32) begin
        busy <= 1'b0;
        if (is_div) begin
          result <= neg ? 32'(-acc[31:0]) : acc[31:0];
          status <= (!neg && acc[31]) ? rpn_pkg::ST_OVER : rpn_pkg::ST_OK;
        end else begin
          result <= prod[31:0];
          status <= (prod > 65'sd2147483647) ? rpn_pkg::ST_OVER :
                    (prod < -65'sd2147483648) ? rpn_pkg::ST_UNDER : rpn_pkg::ST_OK;
        end
      end else begin
        cnt <= cnt + 6'd1;
        if (is_div) begin
          if (!trial[33]) begin
            rem <= trial[32:0];
            acc <= {acc[62:0], 1'b1};
          end else begin
            rem <= {rem[31:0], acc[31]};
            acc <= {acc[62:0], 1'b0};
          end
        end else begin
          // multiplier in low half shifts out as product enters high half
          acc <= acc[0] ? {(33'(acc[63:32]) + 33'(mc)), acc[31:1]}
                        : {1'b0, acc[63:1]};
        end
      end
    end else begin
      done <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/rpn_stack_alu_unit.sv =====
`default_nettype none
// RPN stack calculator for 32-bit signed integers.
// Input channel in_valid/in_ready carries cmd and push_value; output channel
// out_valid/out_ready carries status, top entry and fill level, one result
// per command. Push, duplicate, swap, the unused code and any command that
// fails on a short stack go from S_POP straight to S_DONE; add, subtract,
// multiply and divide wait in S_ARITH for the ALU. Add, subtract and a zero
// divisor need no ALU iteration; multiply and divide run one bit a cycle.
// One command is in flight at a time; in_ready rises the cycle after the
// result is taken.
// The stack is a row of 16 cells that shift together: push moves every entry
// down one place, pop moves them up, so the top is always cell 0.
// Reset empties the stack (count zero) and drops any pending result.
// When the receiver stalls the result holds and in_ready stays low.
module rpn_stack_alu_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rpn_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rpn_pkg::out_t      out_data
);
  localparam int D = rpn_pkg::STACK_DEPTH;
  localparam int CW = rpn_pkg::CW;

  rpn_pkg::state_t    state, state_next;
  rpn_pkg::cell_ctl_t ctl;
  logic [CW-1:0]      count;
  logic [2:0]         cmd;
  logic [31:0]        pv;
  logic [31:0]        opx, opy;
  logic [31:0]        cells [D];
  logic               alu_start, alu_done;
  logic [2:0]         alu_status;
  logic [31:0]        alu_result;
  logic [2:0]         st;
  logic               count_pop2, alu_push;

  genvar g;
  generate
    for (g = 0; g < D; g++) begin : g_cell
      rpn_cell u_cell (
        .clk(clk), .ctl(ctl),
        .above(g == 0 ? 32'b0 : cells[(g == 0) ? 0 : g-1]),
        .below(g == D-1 ? 32'b0 : cells[(g == D-1) ? D-1 : g+1]),
        .is_top(g == 0), .is_second(g == 1),
        .value(cells[g])
      );
    end
  endgenerate

  rpn_alu u_alu (
    .clk(clk), .rst(rst), .start(alu_start), .cmd(cmd), .y(opy), .x(opx),
    .done(alu_done), .status(alu_status), .result(alu_result)
  );

  assign in_ready = (state == rpn_pkg::S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      rpn_pkg::S_IDLE: if (in_valid && in_ready) state_next = rpn_pkg::S_POP;
      rpn_pkg::S_POP: begin
        if ((cmd == rpn_pkg::CMD_ADD || cmd == rpn_pkg::CMD_SUB || cmd == rpn_pkg::CMD_MUL
             || cmd == rpn_pkg::CMD_DIV) && count >= CW'(2))
          state_next = rpn_pkg::S_ARITH;
        else state_next = rpn_pkg::S_DONE;
      end
      rpn_pkg::S_ARITH: if (alu_done) state_next = rpn_pkg::S_DONE;
      rpn_pkg::S_DONE: state_next = rpn_pkg::S_IDLE;
      default: state_next = rpn_pkg::S_IDLE;
    endcase
  end

  // S_POP decides the stack action, S_ARITH pops the second operand; S_DONE pushes an OK ALU result
  always_comb begin
    ctl = '{op: rpn_pkg::SH_HOLD, value: pv};
    alu_start = 1'b0;
    if (state == rpn_pkg::S_POP) begin
      case (cmd)
        rpn_pkg::CMD_PUSH: if (count < CW'(D)) ctl.op = rpn_pkg::SH_PUSH;
        rpn_pkg::CMD_DUP: if (count != '0 && count < CW'(D)) begin
          ctl.op = rpn_pkg::SH_PUSH;
          ctl.value = cells[0];
        end
        rpn_pkg::CMD_SWAP: if (count >= CW'(2)) ctl.op = rpn_pkg::SH_SWAP;
                           else if (count == CW'(1)) ctl.op = rpn_pkg::SH_POP;
        rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
          if (count != '0) ctl.op = rpn_pkg::SH_POP;
          alu_start = (count >= CW'(2));
        end
        default: ;
      endcase
    end else if (state == rpn_pkg::S_ARITH) begin
      ctl.op = count_pop2 ? rpn_pkg::SH_POP : rpn_pkg::SH_HOLD;
    end else if (state == rpn_pkg::S_DONE && alu_push) begin
      ctl.op = rpn_pkg::SH_PUSH;
      ctl.value = alu_result;
    end
  end

  assign opx = cells[0];
  assign opy = cells[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpn_pkg::S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      count_pop2 <= 1'b0;
      alu_push <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == rpn_pkg::S_IDLE && in_valid && in_ready) begin
        cmd <= in_data.cmd;
        pv  <= in_data.push_value;
        alu_push <= 1'b0;
      end
      if (state == rpn_pkg::S_POP) begin
        st <= rpn_pkg::ST_OK;
        case (cmd)
          rpn_pkg::CMD_PUSH:
            if (count < CW'(D)) count <= count + CW'(1); else st <= rpn_pkg::ST_FULL;
          rpn_pkg::CMD_DUP:
            if (count == '0) st <= rpn_pkg::ST_EMPTY;
            else if (count < CW'(D)) count <= count + CW'(1);
            else st <= rpn_pkg::ST_FULL;
          rpn_pkg::CMD_SWAP:
            if (count == '0) st <= rpn_pkg::ST_EMPTY;
            else if (count == CW'(1)) begin
              st <= rpn_pkg::ST_EMPTY;
              count <= '0;
            end
          rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV:
            if (count == '0) st <= rpn_pkg::ST_EMPTY;
            else if (count == CW'(1)) begin
              st <= rpn_pkg::ST_EMPTY;
              count <= '0;
            end else begin
              count <= count - CW'(1);
              count_pop2 <= 1'b1;
            end
          default: ;
        endcase
      end
      if (state == rpn_pkg::S_ARITH) begin
        if (count_pop2) begin
          count <= count - CW'(1);
          count_pop2 <= 1'b0;
        end
        if (alu_done) begin
          st <= alu_status;
          alu_push <= (alu_status == rpn_pkg::ST_OK);
        end
      end
      if (state == rpn_pkg::S_DONE) begin
        out_valid <= 1'b1;
        if (alu_push) count <= count + CW'(1);
      end
    end
  end

  // output built from the post-step stack once out_valid is set (stack settles at DONE edge)
  logic [CW-1:0] cnt_out;
  assign cnt_out = count;
  assign out_data.status     = st;
  assign out_data.top_valid  = (cnt_out != '0);
  assign out_data.top_value  = (cnt_out != '0) ? cells[0] : 32'b0;
  assign out_data.fill_level = 5'(cnt_out);

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(D)) else $error("stack count beyond depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == rpn_pkg::S_IDLE) else $error("ready outside idle");
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    state == rpn_pkg::S_DONE |=> out_valid) else $error("result not presented");
`endif
endmodule
`default_nettype wire
